// ===== rtl/core/tvkd_pkg.sv =====
package tvkd_pkg;

  localparam logic [7:0] CMD_IAC       = 8'd255;
  localparam logic [7:0] CMD_SE        = 8'd240;
  localparam logic [7:0] CMD_SB        = 8'd250;
  localparam logic [7:0] CMD_OPT_FIRST = 8'd251;
  localparam logic [7:0] CMD_OPT_LAST  = 8'd254;
  localparam logic [7:0] KEY_ESC       = 8'd27;
  localparam logic [7:0] KEY_BS        = 8'd8;
  localparam logic [7:0] KEY_DEL       = 8'd127;
  localparam logic [7:0] KEY_ETX       = 8'd3;
  localparam logic [7:0] KEY_EOT       = 8'd4;
  localparam logic [7:0] KEY_CR        = 8'h0D;
  localparam logic [7:0] KEY_LF        = 8'h0A;
  localparam logic [7:0] KEY_NUL       = 8'h00;
  localparam logic [7:0] KEY_CSI       = 8'h5B;
  localparam logic [7:0] KEY_SS3       = 8'h4F;
  localparam logic [7:0] KEY_ARROW_LO  = 8'h41;
  localparam logic [7:0] KEY_ARROW_HI  = 8'h44;

  localparam logic [3:0] EV_CHAR  = 4'd0;
  localparam logic [3:0] EV_LINE  = 4'd1;
  localparam logic [3:0] EV_DEL   = 4'd2;
  localparam logic [3:0] EV_CLOSE = 4'd3;
  localparam logic [3:0] EV_UP    = 4'd4;
  localparam logic [3:0] EV_UNSUP = 4'd8;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned DATA_W      = 16;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_ESC_HELD,
    MODE_IAC,
    MODE_IAC_OPT
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held;
    logic       sub;
    logic       closed;
  } dec_state_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] code;
    logic       last;
  } ev_t;

  typedef struct packed {
    logic [1:0] n;
    ev_t        ev0;
    ev_t        ev1;
  } ev_pair_t;

  typedef struct packed {
    dec_state_t st;
    logic       vld;
    ev_t        ev;
  } feed_res_t;

  typedef struct packed {
    dec_state_t st;
    ev_pair_t   evs;
  } step_res_t;

  function automatic feed_res_t feed(dec_state_t s, logic [7:0] b);
    feed_res_t r;
    r.st  = s;
    r.vld = 1'b0;
    r.ev  = '0;
    if (!s.closed) begin
      unique case (s.mode)
        MODE_ESC: begin
          r.st.held = b;
          r.st.mode = MODE_ESC_HELD;
        end
        MODE_IAC: begin
          r.st.mode = MODE_IDLE;
          if (b >= CMD_OPT_FIRST && b <= CMD_OPT_LAST) begin
            r.st.mode = MODE_IAC_OPT;
          end else if (b == CMD_SE) begin
            r.st.sub = 1'b0;
          end else if (b == CMD_SB) begin
            r.st.sub = 1'b1;
          end else if (b != CMD_IAC) begin
            r.vld     = 1'b1;
            r.ev.kind = EV_UNSUP;
            r.ev.code = b;
          end
        end
        MODE_IAC_OPT: begin
          r.st.mode = MODE_IDLE;
        end
        default: begin
          r.st.mode = MODE_IDLE;
          if (b == CMD_IAC) begin
            r.st.mode = MODE_IAC;
          end else if (b == KEY_ESC) begin
            r.st.mode = MODE_ESC;
          end else if (!s.sub) begin
            if (b == KEY_CR) begin
              r.vld     = 1'b1;
              r.ev.kind = EV_LINE;
            end else if (b == KEY_BS || b == KEY_DEL) begin
              r.vld     = 1'b1;
              r.ev.kind = EV_DEL;
            end else if (b == KEY_ETX || b == KEY_EOT) begin
              r.vld       = 1'b1;
              r.ev.kind   = EV_CLOSE;
              r.st.closed = 1'b1;
              r.st.held   = 8'd0;
            end else if (b != KEY_NUL && b != KEY_LF) begin
              r.vld     = 1'b1;
              r.ev.kind = EV_CHAR;
              r.ev.code = b;
            end
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic step_res_t step(dec_state_t s, logic [7:0] b, logic peer_closed);
    step_res_t r;
    dec_state_t t;
    feed_res_t  f1;
    feed_res_t  f2;
    r.st  = s;
    r.evs = '0;
    t     = s;
    f1    = '0;
    f2    = '0;
    if (!s.closed) begin
      if (peer_closed) begin
        r.st.closed      = 1'b1;
        r.st.mode        = MODE_IDLE;
        r.st.held        = 8'd0;
        r.evs.n          = 2'd1;
        r.evs.ev0.kind   = EV_CLOSE;
      end else if (s.mode == MODE_ESC_HELD) begin
        t.mode = MODE_IDLE;
        t.held = 8'd0;
        if (s.held == KEY_CSI || s.held == KEY_SS3) begin
          if (b >= KEY_ARROW_LO && b <= KEY_ARROW_HI) begin
            f2.st     = t;
            f2.vld    = 1'b1;
            f2.ev.kind = EV_UP + 4'(b - KEY_ARROW_LO);
          end else begin
            f2 = feed(t, b);
          end
        end else begin
          f1 = feed(t, s.held);
          f2 = feed(f1.st, b);
        end
        r.st = f2.st;
        if (f1.vld) begin
          r.evs.ev0 = f1.ev;
          r.evs.ev1 = f2.ev;
          r.evs.n   = f2.vld ? 2'd2 : 2'd1;
        end else begin
          r.evs.ev0 = f2.ev;
          r.evs.n   = {1'b0, f2.vld};
        end
      end else begin
        f2        = feed(s, b);
        r.st      = f2.st;
        r.evs.ev0 = f2.ev;
        r.evs.n   = {1'b0, f2.vld};
      end
    end
    r.evs.ev0.last = (r.evs.n == 2'd1);
    r.evs.ev1.last = 1'b1;
    return r;
  endfunction

endpackage

// ===== rtl/core/tvkd_decode.sv =====
module tvkd_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               peer_closed,
  output tvkd_pkg::ev_pair_t evs
);
  import tvkd_pkg::*;

  dec_state_t st_r;
  dec_state_t st_nxt;
  step_res_t  res;

  assign res = step(st_r, in_byte, peer_closed);

  always_comb begin
    st_nxt = st_r;
    if (accept) begin
      st_nxt = res.st;
    end
  end

  always_comb begin
    evs = res.evs;
    if (!accept) begin
      evs.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{mode: MODE_IDLE, held: 8'd0, sub: 1'b0, closed: 1'b0};
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/core/tvkd_outq.sv =====
module tvkd_outq #(
  parameter int unsigned DEPTH = tvkd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tvkd_pkg::ev_pair_t push,
  output logic               space_ok,
  output logic               out_vld,
  input  logic               out_rdy,
  output tvkd_pkg::ev_t      out_ev
);
  import tvkd_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  ev_t           mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;
  logic [AW-1:0] wp_plus1;

  assign space_ok = (cnt_r <= CW'(DEPTH - 2));
  assign out_vld  = (cnt_r != '0);
  assign out_ev   = mem[rp_r];
  assign pop      = out_vld & out_rdy;
  assign wp_plus1 = wp_r + AW'(1);

  always_comb begin
    wp_nxt  = wp_r + AW'(push.n);
    rp_nxt  = rp_r + AW'(pop);
    cnt_nxt = cnt_r + CW'(push.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wp_r] <= push.ev0;
    end
    if (push.n == 2'd2) begin
      mem[wp_plus1] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/telnet_vt_key_decoder.sv =====
// Channel | Dir | tdata (low bit up)                  | tuser        | tlast
// in_     | in  | [7:0] in_byte                       | peer_closed  | -
// out_    | out | [3:0] event_kind, [11:4] event_byte | -            | last_of_run
//
// One input beat per cycle while in_tready is high; events enter a 4-entry output queue.
// Zero, one or two events per beat; out_ drains one per cycle while out_tready is high.
// in_tready is high while the queue has room for two events.
// Synchronous active-low reset: parser idle, flags clear, queue empty.
module telnet_vt_key_decoder #(
  parameter int unsigned QUEUE_DEPTH = tvkd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tuser,   // [0] peer_closed
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [tvkd_pkg::DATA_W-1:0] out_tdata,  // [3:0] event_kind, [11:4] event_byte
  output logic                        out_tlast   // last_of_run
);
  import tvkd_pkg::*;

  ev_pair_t evs;
  ev_t      out_ev;
  logic     accept;

  assign accept = in_tvalid & in_tready;

  tvkd_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_tdata),
    .peer_closed (in_tuser),
    .evs         (evs)
  );

  tvkd_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (evs),
    .space_ok (in_tready),
    .out_vld  (out_tvalid),
    .out_rdy  (out_tready),
    .out_ev   (out_ev)
  );

  assign out_tdata = {(DATA_W - 12)'(0), out_ev.code, out_ev.kind};
  assign out_tlast = out_ev.last;

endmodule
